// ===== hdl/xdrb_pkg.sv =====
// Package: shared types, constants and register map of the XOR/DMA register block.
`default_nettype none
package xdrb_pkg;

  localparam int NUM_FUNCS_DEF    = 4;
  localparam int MAX_COPY_LEN_DEF = 256;
  localparam int N_SID            = 4;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 32;
  localparam int ACTIVE_W         = 3;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SID0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SID3   = 3'd4;

  // word offsets in a function window
  localparam logic [9:0] W_OPERAND_A = 10'd0;
  localparam logic [9:0] W_OPERAND_B = 10'd1;
  localparam logic [9:0] W_COMMAND   = 10'd2;
  localparam logic [9:0] W_XOR_RES   = 10'd3;
  localparam logic [9:0] W_IRQ       = 10'd4;
  localparam logic [9:0] W_SRC_LO    = 10'd5;
  localparam logic [9:0] W_SRC_HI    = 10'd6;
  localparam logic [9:0] W_DST_LO    = 10'd7;
  localparam logic [9:0] W_DST_HI    = 10'd8;
  localparam logic [9:0] W_COPY_LEN  = 10'd9;
  localparam logic [9:0] W_COPY_CMD  = 10'd10;
  localparam logic [9:0] W_COPY_STAT = 10'd11;
  localparam logic [9:0] W_FUNC_ID   = 10'd12;
  localparam logic [9:0] W_STREAM_ID = 10'd13;
  localparam logic [9:0] W_RESET     = 10'd14;

  localparam logic [31:0] CMD_CLEAR = 32'd0;
  localparam logic [31:0] CMD_XOR   = 32'd1;
  localparam logic [31:0] COPY_GO   = 32'd1;
  localparam logic [31:0] RESET_KEY = 32'd1;

  localparam logic [1:0] STAT_DONE  = 2'b01;
  localparam logic [1:0] STAT_ERROR = 2'b10;

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  // one memory entry: all state of one function except the irq bit
  typedef struct packed {
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [31:0] last_command;
    logic [31:0] xor_result;
    logic [63:0] copy_source;
    logic [63:0] copy_dest;
    logic [31:0] copy_length;
    logic [31:0] copy_command;
    logic [1:0]  copy_status;
  } func_state_t;

  typedef struct packed {
    logic        en;
    logic        cmd;
    logic [1:0]  func_index;
    logic [9:0]  word_index;
    logic [31:0] wdata;
    logic        copy_ok;
  } access_item_t;

  typedef struct packed {
    func_state_t entry;
    logic [31:0] rdata;
    logic        irq_set;
    logic        irq_clr;
    logic        copy_start;
    logic [63:0] copy_src;
    logic [63:0] copy_dst;
    logic [8:0]  copy_len;
  } access_res_t;

endpackage
`default_nettype wire

// ===== hdl/xdrb_in_if.sv =====
// Interface: input channel carrying one register access item.
`default_nettype none
interface xdrb_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [1:0]  func_index;
  logic [9:0]  word_index;
  logic [31:0] wdata;
  logic        copy_ok;

  modport source (output valid, cmd, func_index, word_index, wdata, copy_ok, input ready);
  modport sink   (input valid, cmd, func_index, word_index, wdata, copy_ok, output ready);
endinterface
`default_nettype wire

// ===== hdl/xdrb_out_if.sv =====
// Interface: result channel carrying one access result item.
`default_nettype none
interface xdrb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] rdata;
  logic [3:0]  irq_lines;
  logic        copy_start;
  logic [63:0] copy_src;
  logic [63:0] copy_dst;
  logic [8:0]  copy_len;

  modport source (output valid, rdata, irq_lines, copy_start, copy_src, copy_dst, copy_len,
                  input ready);
  modport sink   (input valid, rdata, irq_lines, copy_start, copy_src, copy_dst, copy_len,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/xor_dma_register_block.sv =====
// Top level: register file of the multi-function XOR and copy-engine peripheral.
//
// Usage:
//  - in_ch carries one 32-bit register access per item (read or write of one word
//    in one function's window, plus the copy outcome for a copy start).
//  - out_ch returns exactly one result item per access: read data, the per-function
//    interrupt levels after the access, and a copy descriptor when a copy launched.
//  - cfg_* is a plain write port: cfg_we with cfg_index/cfg_wdata writes register
//    0 (active function count) or 1..4 (stream ids); write only while idle.
// Flow:
//  - The accept edge issues the state-memory read; the next edge writes back the
//    modified entry and loads the output register. No new item is accepted while
//    one is executing, because of the memory read-modify-write.
//  - The result is registered and holds until out_ch.ready; a new item
//    may be accepted in the same cycle the pending result is taken.
// Reset (rst_n low, synchronous): memory valid bits, irq bits and the handshake
//  state clear, active count returns to 4 and stream ids to 0; no clearing pass.
// Stall: while the result is not taken, in_ch.ready stays low.
`default_nettype none
module xor_dma_register_block
  import xdrb_pkg::*;
#(
  parameter int NUM_FUNCS    = NUM_FUNCS_DEF,
  parameter int MAX_COPY_LEN = MAX_COPY_LEN_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  xdrb_in_if.sink                    in_ch,
  xdrb_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
  localparam int IW = (NUM_FUNCS > 4) ? NUM_FUNCS : 4;

  // configuration registers
  logic [ACTIVE_W-1:0] active_r;
  logic [31:0]         sid_r [N_SID];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_W'(NUM_FUNCS_DEF);
      for (int i = 0; i < N_SID; i++) begin
        sid_r[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == CFG_ACTIVE) begin
        active_r <= cfg_wdata[ACTIVE_W-1:0];
      end else if (cfg_index >= CFG_SID0 && cfg_index <= CFG_SID3) begin
        sid_r[2'(cfg_index - CFG_SID0)] <= cfg_wdata;
      end
    end
  end

  // handshake and control
  state_t       state_r, state_nxt;
  access_item_t item_r;
  logic         in_acc, out_acc, in_en;
  logic         out_valid_r;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_acc  = out_valid_r && out_ch.ready;
  // one item in flight; output register is free or draining at accept
  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_en    = (int'(in_ch.func_index) < int'(active_r)) &&
                    (int'(in_ch.func_index) < NUM_FUNCS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.en         <= in_en;
      item_r.cmd        <= in_ch.cmd;
      item_r.func_index <= in_ch.func_index;
      item_r.word_index <= in_ch.word_index;
      item_r.wdata      <= in_ch.wdata;
      item_r.copy_ok    <= in_ch.copy_ok;
    end
  end

  // state memory, read at accept, written back in the execute cycle
  func_state_t entry;
  access_res_t res;
  logic [AW-1:0] item_addr;
  logic          exec, wr_en;

  assign item_addr = AW'(item_r.func_index);
  assign exec      = (state_r == ST_EXEC);
  assign wr_en     = exec && item_r.en && item_r.cmd;

  xdrb_state_mem #(
    .DEPTH (NUM_FUNCS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (AW'(in_ch.func_index)),
    .rd_data (entry),
    .wr_en   (wr_en),
    .wr_addr (item_addr),
    .wr_data (res.entry)
  );

  // interrupt pending bits live in flops so all lines are visible at once
  logic [NUM_FUNCS-1:0] irq_r, irq_nxt;
  logic [IW-1:0]        irq_ext;
  logic [3:0]           lines;

  xdrb_access_unit #(
    .MAX_COPY_LEN (MAX_COPY_LEN)
  ) u_access (
    .item      (item_r),
    .entry     (entry),
    .irq_cur   (irq_r[item_addr]),
    .stream_id (sid_r[item_r.func_index]),
    .res       (res)
  );

  always_comb begin
    irq_nxt = irq_r;
    if (exec && item_r.en) begin
      if (res.irq_clr) begin
        irq_nxt[item_addr] = 1'b0;
      end else if (res.irq_set) begin
        irq_nxt[item_addr] = 1'b1;
      end
    end
  end

  assign irq_ext = IW'(irq_nxt);

  // disabled functions show no interrupt
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lines[i] = irq_ext[i] && (i < int'(active_r)) && (i < NUM_FUNCS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      irq_r <= '0;
    end else begin
      irq_r <= irq_nxt;
    end
  end

  // output register
  logic [31:0] rdata_r;
  logic [3:0]  irq_lines_r;
  logic        copy_start_r;
  logic [63:0] copy_src_r, copy_dst_r;
  logic [8:0]  copy_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec) begin
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      rdata_r      <= res.rdata;
      irq_lines_r  <= lines;
      copy_start_r <= res.copy_start;
      copy_src_r   <= res.copy_src;
      copy_dst_r   <= res.copy_dst;
      copy_len_r   <= res.copy_len;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.rdata      = rdata_r;
  assign out_ch.irq_lines  = irq_lines_r;
  assign out_ch.copy_start = copy_start_r;
  assign out_ch.copy_src   = copy_src_r;
  assign out_ch.copy_dst   = copy_dst_r;
  assign out_ch.copy_len   = copy_len_r;

endmodule
`default_nettype wire

// ===== hdl/xdrb_state_mem.sv =====
// Per-function state memory: registered read, valid bits give zero reset.
`default_nettype none
module xdrb_state_mem
  import xdrb_pkg::*;
#(
  parameter int DEPTH = NUM_FUNCS_DEF,
  parameter int AW    = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output func_state_t      rd_data,
  input  wire logic        wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire func_state_t wr_data
);

  func_state_t mem [DEPTH];
  func_state_t rd_data_r;
  logic [DEPTH-1:0] vld_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // never-written entry reads as its reset value
  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule
`default_nettype wire

// ===== hdl/xdrb_access_unit.sv =====
// Access unit: decodes one access and forms the modified entry and the result.
`default_nettype none
module xdrb_access_unit
  import xdrb_pkg::*;
#(
  parameter int MAX_COPY_LEN = MAX_COPY_LEN_DEF
) (
  input  wire access_item_t item,
  input  wire func_state_t  entry,
  input  wire logic     irq_cur,
  input  wire logic [31:0] stream_id,
  output access_res_t   res
);

  logic        bad_len;
  logic [31:0] v;

  assign v       = item.wdata;
  assign bad_len = (entry.copy_length == 32'd0) ||
                   (entry.copy_length > 32'(MAX_COPY_LEN));

  always_comb begin
    res       = '0;
    res.entry = entry;
    if (item.en && !item.cmd) begin
      unique case (item.word_index)
        W_OPERAND_A: res.rdata = entry.operand_a;
        W_OPERAND_B: res.rdata = entry.operand_b;
        W_COMMAND:   res.rdata = entry.last_command;
        W_XOR_RES:   res.rdata = entry.xor_result;
        W_IRQ:       res.rdata = {31'd0, irq_cur};
        W_SRC_LO:    res.rdata = entry.copy_source[31:0];
        W_SRC_HI:    res.rdata = entry.copy_source[63:32];
        W_DST_LO:    res.rdata = entry.copy_dest[31:0];
        W_DST_HI:    res.rdata = entry.copy_dest[63:32];
        W_COPY_LEN:  res.rdata = entry.copy_length;
        W_COPY_CMD:  res.rdata = entry.copy_command;
        W_COPY_STAT: res.rdata = {30'd0, entry.copy_status};
        W_FUNC_ID:   res.rdata = {30'd0, item.func_index};
        W_STREAM_ID: res.rdata = stream_id;
        default:     res.rdata = '0;
      endcase
    end else if (item.en && item.cmd) begin
      unique case (item.word_index)
        W_OPERAND_A: res.entry.operand_a = v;
        W_OPERAND_B: res.entry.operand_b = v;
        W_COMMAND: begin
          res.entry.last_command = v;
          if (v == CMD_XOR) begin
            res.entry.xor_result = entry.operand_a ^ entry.operand_b;
            res.irq_set          = 1'b1;
          end else if (v == CMD_CLEAR) begin
            res.entry.xor_result = '0;
          end
        end
        W_IRQ:       res.irq_clr = v[0];
        W_SRC_LO:    res.entry.copy_source[31:0]  = v;
        W_SRC_HI:    res.entry.copy_source[63:32] = v;
        W_DST_LO:    res.entry.copy_dest[31:0]    = v;
        W_DST_HI:    res.entry.copy_dest[63:32]   = v;
        W_COPY_LEN:  res.entry.copy_length        = v;
        W_COPY_CMD: begin
          res.entry.copy_command = v;
          if (v == COPY_GO) begin
            res.irq_set = 1'b1;
            if (bad_len) begin
              res.entry.copy_status = STAT_ERROR;
            end else begin
              res.copy_start        = 1'b1;
              res.copy_src          = entry.copy_source;
              res.copy_dst          = entry.copy_dest;
              res.copy_len          = entry.copy_length[8:0];
              res.entry.copy_status = item.copy_ok ? STAT_DONE : STAT_ERROR;
            end
          end
        end
        W_COPY_STAT: res.entry.copy_status = entry.copy_status & ~v[1:0];
        W_RESET: begin
          if (v == RESET_KEY) begin
            res.entry   = '0;
            res.irq_clr = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/xdrb_checker.sv =====
// Checker: port-level assertions on the register block, bound to the top level.
`default_nettype none
module xdrb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        copy_start,
  input wire logic [63:0] copy_src,
  input wire logic [63:0] copy_dst,
  input wire logic [8:0]  copy_len
);

  // pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one item in flight: no accept in the cycle after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted during execute");

  // each accepted item shows its result once the execute state has passed
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("result missing after accept");

  // no descriptor without a launched copy
  a_desc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !copy_start |-> copy_src == 64'd0 && copy_dst == 64'd0 && copy_len == 9'd0)
    else $error("copy descriptor set without copy start");

endmodule

bind xor_dma_register_block xdrb_checker u_xdrb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .copy_start (out_ch.copy_start),
  .copy_src   (out_ch.copy_src),
  .copy_dst   (out_ch.copy_dst),
  .copy_len   (out_ch.copy_len)
);
`default_nettype wire
